// File: hdl/idh_pkg.sv
package idh_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CW       = $clog2(CAPACITY + 1);
  localparam int unsigned IW       = AW + 2;
  localparam int unsigned KW       = 32;
  localparam int unsigned OCC_W    = 11;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_POP_MIN = 2'd1;
  localparam logic [1:0] OP_POP_MAX = 2'd2;

  typedef logic signed [KW-1:0] key_t;
  typedef logic [AW-1:0]        slot_t;
  typedef logic [IW-1:0]        idx_t;
  typedef logic [CW-1:0]        cnt_t;

  typedef struct packed {
    logic [1:0] operation;
    key_t       value;
  } cmd_t;

  typedef struct packed {
    key_t             minimum;
    key_t             maximum;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
    logic             rejected;
  } res_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    key_t  wdata;
    slot_t raddr;
  } ram_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_PAIR,
    S_UP_START,
    S_UP_CHKMIN,
    S_UP_CHKMAX,
    S_UP_NEXT,
    S_UP_CMP,
    S_MIN_LOAD,
    S_MIN_FIX,
    S_MIN_FIXCMP,
    S_MIN_CHILD,
    S_MIN_C1,
    S_MIN_C2,
    S_MAX_LOAD,
    S_MAX_FIX,
    S_MAX_FIXCMP,
    S_MAX_K1,
    S_MAX_K2,
    S_MAX_K3,
    S_WR_CUR,
    S_FIN0,
    S_FIN1,
    S_FIN2
  } state_e;

  function automatic logic key_lt(key_t a, key_t b);
    return a < b;
  endfunction

endpackage

// File: hdl/idh_ram.sv
module idh_ram
  import idh_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output key_t     rdata_o
);

  key_t mem_q [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

// File: hdl/interval_heap_depq.sv
// One item at a time; each tree level of a sift goes through the single read port of the
//   key memory. start is taken again in the result cycle.
// Reset clears the key count, the state and the result valid flag; the key memory
//   keeps its contents, no clearing pass.
// The result beat lasts one cycle on res_valid_o; the receiver cannot stall it.
module interval_heap_depq
  import idh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output res_t res_o
);

  state_e   state_q, state_d;
  cnt_t     cnt_q, cnt_d;
  key_t     cur_q, cur_d;
  slot_t    pos_q, pos_d;
  logic     max_q, max_d;
  key_t     bestv_q, bestv_d;
  logic     rej_q, rej_d;
  key_t     min_q, min_d;
  res_t     res_q, res_d;
  logic     res_valid_q, res_valid_d;
  ram_req_t mem_req;
  key_t     rdata;

  slot_t up_node, up_lo;
  idx_t  posx, cntx, mchild, m2, c1hi, c1lo, c2hi, c2lo;

  idh_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign up_node = pos_q >> 1;
  assign up_lo   = ((up_node - slot_t'(1)) >> 1) << 1;
  assign posx    = IW'(pos_q);
  assign cntx    = IW'(cnt_q);
  assign mchild  = (posx << 1) + idx_t'(2);
  assign m2      = mchild + idx_t'(2);
  assign c1hi    = (posx << 1) + idx_t'(1);
  assign c1lo    = posx << 1;
  assign c2hi    = (posx << 1) + idx_t'(3);
  assign c2lo    = (posx << 1) + idx_t'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    pos_q   <= pos_d;
    max_q   <= max_d;
    bestv_q <= bestv_d;
    rej_q   <= rej_d;
    min_q   <= min_d;
    res_q   <= res_d;
  end

  always_comb begin
    logic  min_dec;
    logic  max_dec;
    key_t  dec_val;
    idx_t  dec_idx;
    logic  mv;
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    max_d       = max_q;
    bestv_d     = bestv_q;
    rej_d       = rej_q;
    min_d       = min_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_req     = '0;
    min_dec     = 1'b0;
    max_dec     = 1'b0;
    dec_val     = rdata;
    dec_idx     = '0;
    mv          = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          rej_d = 1'b0;
          case (cmd_i.operation)
            OP_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                rej_d   = 1'b1;
                state_d = S_FIN0;
              end else begin
                cur_d = cmd_i.value;
                pos_d = slot_t'(cnt_q);
                cnt_d = cnt_q + CW'(1);
                if (cnt_q[0]) begin
                  mem_req.raddr = slot_t'(cnt_q) - slot_t'(1);
                  state_d       = S_INS_PAIR;
                end else begin
                  state_d = S_UP_START;
                end
              end
            end
            OP_POP_MIN: begin
              if (cnt_q == '0) begin
                state_d = S_FIN0;
              end else begin
                cnt_d = cnt_q - CW'(1);
                if (cnt_q == CW'(1)) begin
                  state_d = S_FIN0;
                end else begin
                  mem_req.raddr = slot_t'(cnt_q - CW'(1));
                  state_d       = S_MIN_LOAD;
                end
              end
            end
            OP_POP_MAX: begin
              if (cnt_q == '0) begin
                state_d = S_FIN0;
              end else begin
                cnt_d = cnt_q - CW'(1);
                if (cnt_q <= CW'(2)) begin
                  state_d = S_FIN0;
                end else begin
                  mem_req.raddr = slot_t'(cnt_q - CW'(1));
                  state_d       = S_MAX_LOAD;
                end
              end
            end
            default: begin
              state_d = S_FIN0;
            end
          endcase
        end
      end

      S_INS_PAIR: begin
        if (key_lt(cur_q, rdata)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          mem_req.wdata = rdata;
          pos_d         = pos_q - slot_t'(1);
        end
        state_d = S_UP_START;
      end

      S_UP_START: begin
        if (up_node == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          mem_req.wdata = cur_q;
          state_d       = S_FIN0;
        end else begin
          mem_req.raddr = up_lo;
          state_d       = S_UP_CHKMIN;
        end
      end

      S_UP_CHKMIN: begin
        if (key_lt(cur_q, rdata)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          mem_req.wdata = rdata;
          pos_d         = up_lo;
          max_d         = 1'b0;
          state_d       = S_UP_NEXT;
        end else begin
          mem_req.raddr = up_lo | slot_t'(1);
          state_d       = S_UP_CHKMAX;
        end
      end

      S_UP_CHKMAX: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q;
        if (key_lt(rdata, cur_q)) begin
          mem_req.wdata = rdata;
          pos_d         = up_lo | slot_t'(1);
          max_d         = 1'b1;
          state_d       = S_UP_NEXT;
        end else begin
          mem_req.wdata = cur_q;
          state_d       = S_FIN0;
        end
      end

      S_UP_NEXT: begin
        if (up_node == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          mem_req.wdata = cur_q;
          state_d       = S_FIN0;
        end else begin
          mem_req.raddr = up_lo | slot_t'(max_q);
          state_d       = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mv            = max_q ? key_lt(rdata, cur_q) : key_lt(cur_q, rdata);
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q;
        if (mv) begin
          mem_req.wdata = rdata;
          pos_d         = up_lo | slot_t'(max_q);
          state_d       = S_UP_NEXT;
        end else begin
          mem_req.wdata = cur_q;
          state_d       = S_FIN0;
        end
      end

      S_MIN_LOAD: begin
        cur_d   = rdata;
        pos_d   = '0;
        state_d = S_MIN_FIX;
      end

      S_MIN_FIX: begin
        if (posx + idx_t'(1) < cntx) begin
          mem_req.raddr = pos_q + slot_t'(1);
          state_d       = S_MIN_FIXCMP;
        end else begin
          state_d = S_MIN_CHILD;
        end
      end

      S_MIN_FIXCMP: begin
        if (key_lt(rdata, cur_q)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q + slot_t'(1);
          mem_req.wdata = cur_q;
          cur_d         = rdata;
        end
        state_d = S_MIN_CHILD;
      end

      S_MIN_CHILD: begin
        if (mchild >= cntx) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          mem_req.wdata = cur_q;
          state_d       = S_FIN0;
        end else begin
          mem_req.raddr = slot_t'(mchild);
          state_d       = S_MIN_C1;
        end
      end

      S_MIN_C1: begin
        if (m2 < cntx) begin
          bestv_d       = rdata;
          mem_req.raddr = slot_t'(m2);
          state_d       = S_MIN_C2;
        end else begin
          min_dec = 1'b1;
          dec_val = rdata;
          dec_idx = mchild;
        end
      end

      S_MIN_C2: begin
        min_dec = 1'b1;
        if (key_lt(rdata, bestv_q)) begin
          dec_val = rdata;
          dec_idx = m2;
        end else begin
          dec_val = bestv_q;
          dec_idx = mchild;
        end
      end

      S_MAX_LOAD: begin
        cur_d   = rdata;
        pos_d   = slot_t'(1);
        state_d = S_MAX_FIX;
      end

      S_MAX_FIX: begin
        mem_req.raddr = pos_q - slot_t'(1);
        state_d       = S_MAX_FIXCMP;
      end

      S_MAX_FIXCMP: begin
        if (key_lt(cur_q, rdata)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q - slot_t'(1);
          mem_req.wdata = cur_q;
          cur_d         = rdata;
        end
        state_d = S_MAX_K1;
      end

      S_MAX_K1: begin
        if (c1hi < cntx) begin
          mem_req.raddr = slot_t'(c1hi);
          state_d       = S_MAX_K2;
        end else if (c1lo < cntx) begin
          mem_req.raddr = slot_t'(c1lo);
          state_d       = S_MAX_K2;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          mem_req.wdata = cur_q;
          state_d       = S_FIN0;
        end
      end

      S_MAX_K2: begin
        bestv_d = rdata;
        if (c2hi < cntx) begin
          mem_req.raddr = slot_t'(c2hi);
          state_d       = S_MAX_K3;
        end else if (c2lo < cntx) begin
          mem_req.raddr = slot_t'(c2lo);
          state_d       = S_MAX_K3;
        end else begin
          max_dec = 1'b1;
          dec_val = rdata;
          dec_idx = (c1hi < cntx) ? c1hi : c1lo;
        end
      end

      S_MAX_K3: begin
        max_dec = 1'b1;
        if (key_lt(bestv_q, rdata)) begin
          dec_val = rdata;
          dec_idx = (c2hi < cntx) ? c2hi : c2lo;
        end else begin
          dec_val = bestv_q;
          dec_idx = (c1hi < cntx) ? c1hi : c1lo;
        end
      end

      S_WR_CUR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q;
        mem_req.wdata = cur_q;
        state_d       = S_FIN0;
      end

      S_FIN0: begin
        mem_req.raddr = '0;
        state_d       = S_FIN1;
      end

      S_FIN1: begin
        min_d         = rdata;
        mem_req.raddr = slot_t'(1);
        state_d       = S_FIN2;
      end

      S_FIN2: begin
        res_d.occupancy = OCC_W'(cnt_q);
        res_d.is_empty  = (cnt_q == '0);
        res_d.rejected  = rej_q;
        if (cnt_q == '0) begin
          res_d.minimum = '0;
          res_d.maximum = '0;
        end else if (cnt_q == CW'(1)) begin
          res_d.minimum = min_q;
          res_d.maximum = min_q;
        end else begin
          res_d.minimum = min_q;
          res_d.maximum = rdata;
        end
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // descend one level or drop the moving key in place
    if (min_dec) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = pos_q;
      if (key_lt(dec_val, cur_q)) begin
        mem_req.wdata = dec_val;
        pos_d         = slot_t'(dec_idx);
        state_d       = S_MIN_FIX;
      end else begin
        mem_req.wdata = cur_q;
        state_d       = S_FIN0;
      end
    end

    if (max_dec) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = pos_q;
      if (key_lt(cur_q, dec_val)) begin
        mem_req.wdata = dec_val;
        pos_d         = slot_t'(dec_idx);
        state_d       = dec_idx[0] ? S_MAX_FIX : S_WR_CUR;
      end else begin
        mem_req.wdata = cur_q;
        state_d       = S_FIN0;
      end
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not start work");

  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result beat while still working");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("key count beyond capacity");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == S_FIN2))
    else $error("result beat without finishing step");

endmodule

// File: verif/interval_heap_depq_tb.sv
`timescale 1ns / 100ps

module interval_heap_depq_tb;
  import idh_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned MAX_SHOWN = 10;
  localparam key_t KEY_MAX = 32'sh7fffffff;
  localparam key_t KEY_MIN = 32'sh80000000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic res_valid_o;
  res_t res_o;

  key_t        heap_keys [CAPACITY];
  int unsigned key_count;
  res_t        pending_status [$];
  int unsigned mismatch_cnt;
  int unsigned quiet_run;

  interval_heap_depq dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic void swap_keys(int a, int b);
    key_t t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void raise_key(int pos, bit to_max);
    int par;
    int tgt;
    bit move;
    while ((pos >> 1) != 0) begin
      par = ((pos >> 1) - 1) >> 1;
      tgt = to_max ? 2 * par + 1 : 2 * par;
      move = to_max ? (heap_keys[tgt] < heap_keys[pos]) : (heap_keys[pos] < heap_keys[tgt]);
      if (!move) break;
      swap_keys(pos, tgt);
      pos = tgt;
    end
  endfunction

  function automatic void insert_key(key_t v);
    int pos;
    int par;
    pos = key_count;
    heap_keys[pos] = v;
    key_count++;
    if (pos[0] && heap_keys[pos] < heap_keys[pos-1]) begin
      swap_keys(pos, pos - 1);
      pos--;
    end
    if ((pos >> 1) == 0) return;
    par = ((pos >> 1) - 1) >> 1;
    if (heap_keys[pos] < heap_keys[2*par]) begin
      raise_key(pos, 1'b0);
    end else if (heap_keys[2*par+1] < heap_keys[pos]) begin
      raise_key(pos, 1'b1);
    end
  endfunction

  function automatic void order_pair(int node);
    int lo;
    lo = 2 * node;
    if (lo + 1 < key_count && heap_keys[lo+1] < heap_keys[lo]) swap_keys(lo, lo + 1);
  endfunction

  function automatic void sink_min();
    int node;
    int slot;
    int m;
    node = 0;
    forever begin
      order_pair(node);
      slot = 2 * node;
      m = 4 * node + 2;
      if (m >= key_count) break;
      if (m + 2 < key_count && heap_keys[m+2] < heap_keys[m]) m += 2;
      if (!(heap_keys[m] < heap_keys[slot])) break;
      swap_keys(slot, m);
      node = m >> 1;
    end
  endfunction

  function automatic void sink_max();
    int node;
    int slot;
    int c;
    int best;
    bit have;
    node = 0;
    forever begin
      slot = 2 * node + 1;
      if (slot >= key_count) break;
      order_pair(node);
      have = 1'b0;
      best = 0;
      for (int k = 1; k <= 2; k++) begin
        c = 2 * node + k;
        if (2 * c + 1 < key_count) begin
          c = 2 * c + 1;
        end else if (2 * c < key_count) begin
          c = 2 * c;
        end else begin
          continue;
        end
        if (!have || heap_keys[best] < heap_keys[c]) begin
          best = c;
          have = 1'b1;
        end
      end
      if (!have || !(heap_keys[slot] < heap_keys[best])) break;
      swap_keys(slot, best);
      if (best[0] == 1'b0) break;
      node = best >> 1;
    end
  endfunction

  function automatic res_t apply_cmd(cmd_t c);
    res_t r;
    r = '0;
    case (c.operation)
      OP_INSERT: begin
        if (key_count >= CAPACITY) r.rejected = 1'b1;
        else insert_key(c.value);
      end
      OP_POP_MIN: begin
        if (key_count > 0) begin
          key_count--;
          if (key_count > 0) begin
            heap_keys[0] = heap_keys[key_count];
            sink_min();
          end
        end
      end
      OP_POP_MAX: begin
        if (key_count > 0) begin
          key_count--;
          if (key_count > 1) begin
            heap_keys[1] = heap_keys[key_count];
            sink_max();
          end
        end
      end
      default: ;
    endcase
    if (key_count >= 1) begin
      r.minimum = heap_keys[0];
      r.maximum = (key_count >= 2) ? heap_keys[1] : heap_keys[0];
    end
    r.occupancy = key_count[OCC_W-1:0];
    r.is_empty  = (key_count == 0);
    return r;
  endfunction

  function automatic key_t rand_key();
    case ($urandom_range(0, 7))
      0, 1, 2: return key_t'($urandom_range(0, 8)) - key_t'(4);
      3:       return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
      default: return key_t'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] rand_pop();
    return $urandom_range(0, 1) ? OP_POP_MAX : OP_POP_MIN;
  endfunction

  // enter and leave on a falling edge
  task automatic send_cmd(logic [1:0] op, key_t val);
    int unsigned gap;
    cmd_t c;
    if (quiet_run > 0) begin
      gap = 0;
      quiet_run--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      quiet_run = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 9);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    c.operation = op;
    c.value = val;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    pending_status = {pending_status, apply_cmd(c)};
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_status
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_status.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
          $display("%0t: unexpected result beat min=%0d max=%0d occ=%0d",
                   $time, res_o.minimum, res_o.maximum, res_o.occupancy);
      end else begin
        want = pending_status.pop_front();
        if (res_o.minimum !== want.minimum || res_o.maximum !== want.maximum ||
            res_o.occupancy !== want.occupancy || res_o.is_empty !== want.is_empty ||
            res_o.rejected !== want.rejected) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN) begin
            $display("%0t: exp min=%0d max=%0d occ=%0d empty=%0b rej=%0b",
                     $time, want.minimum, want.maximum, want.occupancy,
                     want.is_empty, want.rejected);
            $display("%0t: got min=%0d max=%0d occ=%0d empty=%0b rej=%0b",
                     $time, res_o.minimum, res_o.maximum, res_o.occupancy,
                     res_o.is_empty, res_o.rejected);
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(OP_POP_MIN, 0);
    send_cmd(OP_POP_MAX, 0);
    send_cmd(OP_UNUSED, KEY_MAX);
    send_cmd(OP_INSERT, KEY_MAX);
    send_cmd(OP_POP_MAX, 0);
    send_cmd(OP_INSERT, KEY_MIN);
    send_cmd(OP_INSERT, KEY_MAX);
    send_cmd(OP_UNUSED, 0);
    send_cmd(OP_POP_MIN, 0);
    send_cmd(OP_POP_MAX, 0);
    send_cmd(OP_INSERT, 50);
    send_cmd(OP_INSERT, 0);
    send_cmd(OP_INSERT, 40);
    send_cmd(OP_INSERT, -1);
    send_cmd(OP_INSERT, 30);
    send_cmd(OP_INSERT, 20);
    send_cmd(OP_POP_MAX, 0);
    send_cmd(OP_POP_MAX, 0);
    send_cmd(OP_POP_MIN, 0);
    send_cmd(OP_INSERT, 7);
    send_cmd(OP_INSERT, 7);
    send_cmd(OP_INSERT, 7);
    send_cmd(OP_POP_MIN, 0);
  endtask

  task automatic test_random_small();
    int unsigned pick;
    for (int i = 0; i < 80; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < ((key_count > 12) ? 30 : 50)) send_cmd(OP_INSERT, rand_key());
      else if (pick < 95) send_cmd(rand_pop(), rand_key());
      else send_cmd(OP_UNUSED, rand_key());
    end
  endtask

  task automatic test_fill();
    while (key_count < CAPACITY) begin
      if ($urandom_range(0, 31) == 0) send_cmd(rand_pop(), rand_key());
      else send_cmd(OP_INSERT, rand_key());
    end
  endtask

  task automatic test_full();
    int unsigned pick;
    for (int i = 0; i < 40; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) send_cmd(OP_INSERT, rand_key());
      else if (pick < 9) send_cmd(rand_pop(), rand_key());
      else send_cmd(OP_UNUSED, rand_key());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    key_count = 0;
    mismatch_cnt = 0;
    quiet_run = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_small();
    test_fill();
    test_full();
    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_status.size() == 0) begin
      $display("[interval_heap_depq] OK");
    end else begin
      $display("[interval_heap_depq] ERROR");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("[interval_heap_depq] ERROR");
    $finish;
  end

endmodule
